### design/utf8s_pkg.sv
// ----------------------------------------------------------------------------
// utf8s_pkg
// Shared types, constants and byte classification for the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
package utf8s_pkg;

  localparam logic [7:0] QMARK       = 8'h3F;
  localparam logic [7:0] TERMINATOR  = 8'h00;

  // Most words one input byte can produce.
  localparam int MAX_BURST  = 4;
  localparam int BURST_NW   = 3;

  // Result queue: a power of two, at least MAX_BURST deep.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  localparam logic [16:0] CAP_RESET_LIMIT = 17'd255;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8s_word_t;

  // Words produced by one input byte, in order, slot 0 first.
  typedef struct packed {
    logic [BURST_NW-1:0]              count;
    utf8s_word_t [MAX_BURST-1:0]      word;
  } utf8s_burst_t;

  // Expected sequence length of a lead byte, zero when not a valid lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if ((b & 8'hE0) == 8'hC0) begin
      if (b >= 8'hC2) len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      if (b <= 8'hF4) len = 3'd4;
    end
    return len;
  endfunction

  // Range rules on the first continuation byte: overlongs, surrogates, > U+10FFFF.
  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    ok = 1'b1;
    if (lead == 8'hE0 && b < 8'hA0) ok = 1'b0;
    if (lead == 8'hED && b > 8'h9F) ok = 1'b0;
    if (lead == 8'hF0 && b < 8'h90) ok = 1'b0;
    if (lead == 8'hF4 && b > 8'h8F) ok = 1'b0;
    return ok;
  endfunction

  // ASCII byte as emitted: keep tab, LF, CR and printables.
  function automatic logic [7:0] ascii_map(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b < 8'h20 && b != 8'h09 && b != 8'h0D && b != 8'h0A) r = QMARK;
    return r;
  endfunction

endpackage

### design/utf8s_decode.sv
// ----------------------------------------------------------------------------
// utf8s_decode
// Sequence state and per-byte decision: turns one input byte into a burst.
// ----------------------------------------------------------------------------
module utf8s_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  input  logic [15:0]          text_limit,
  output utf8s_pkg::utf8s_burst_t burst
);

  logic [7:0]  held_bytes [3];
  logic [1:0]  held_count;
  logic [2:0]  seq_len;
  logic [15:0] written_count;

  logic [7:0]  held_next [3];
  logic [1:0]  held_count_next;
  logic [2:0]  seq_len_next;
  logic [15:0] written_count_next;

  logic [7:0]  cand [4];
  logic [2:0]  n_cand;
  logic        term;
  logic [2:0]  room;
  logic [2:0]  n_text;
  logic [15:0] room_diff;
  logic [2:0]  fresh_len;
  logic [7:0]  fresh_byte;
  logic        cont_ok;

  always_comb begin
    held_next          = held_bytes;
    held_count_next    = held_count;
    seq_len_next       = seq_len;
    term               = 1'b0;
    n_cand             = 3'd0;
    for (int k = 0; k < 4; k++) cand[k] = utf8s_pkg::QMARK;

    fresh_len  = utf8s_pkg::lead_len(in_byte);
    fresh_byte = in_byte[7] ? utf8s_pkg::QMARK : utf8s_pkg::ascii_map(in_byte);
    cont_ok    = (in_byte[7:6] == 2'b10) &&
                 (held_count != 2'd1 || utf8s_pkg::second_ok(held_bytes[0], in_byte));

    room_diff = text_limit - written_count;
    if (written_count >= text_limit) room = 3'd0;
    else if (room_diff >= 16'd4)     room = 3'd4;
    else                             room = room_diff[2:0];

    if (in_byte == utf8s_pkg::TERMINATOR) begin
      // flush held bytes as '?', then the terminator
      n_cand          = {1'b0, held_count};
      term            = 1'b1;
      held_count_next = 2'd0;
      seq_len_next    = 3'd0;
    end else if (room == 3'd0) begin
      // full: drop the byte and any partial sequence
      held_count_next = 2'd0;
      seq_len_next    = 3'd0;
    end else if (held_count != 2'd0 && cont_ok) begin
      if ({1'b0, held_count} + 3'd1 >= seq_len) begin
        for (int k = 0; k < 4; k++) begin
          if (3'(k) < {1'b0, held_count})      cand[k] = held_bytes[k[1:0]];
          else if (3'(k) == {1'b0, held_count}) cand[k] = in_byte;
        end
        n_cand          = {1'b0, held_count} + 3'd1;
        held_count_next = 2'd0;
        seq_len_next    = 3'd0;
      end else begin
        held_next[held_count] = in_byte;
        held_count_next       = held_count + 2'd1;
      end
    end else begin
      // broken sequence (if any) becomes '?', then examine the byte afresh
      n_cand = {1'b0, held_count};
      if (fresh_len != 3'd0) begin
        held_next[0]    = in_byte;
        held_count_next = 2'd1;
        seq_len_next    = fresh_len;
      end else begin
        for (int k = 0; k < 4; k++) begin
          if (3'(k) == {1'b0, held_count}) cand[k] = fresh_byte;
        end
        n_cand          = {1'b0, held_count} + 3'd1;
        held_count_next = 2'd0;
        seq_len_next    = 3'd0;
      end
    end

    n_text = (n_cand < room) ? n_cand : room;

    for (int k = 0; k < 4; k++) begin
      if (3'(k) < n_text) begin
        burst.word[k].data = cand[k];
        burst.word[k].last = 1'b0;
      end else begin
        burst.word[k].data = utf8s_pkg::TERMINATOR;
        burst.word[k].last = term;
      end
    end
    burst.count = n_text + {2'b00, term};

    written_count_next = term ? 16'd0 : written_count + {13'd0, n_text};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= 2'd0;
      seq_len       <= 3'd0;
      written_count <= 16'd0;
    end else if (accept) begin
      held_count    <= held_count_next;
      seq_len       <= seq_len_next;
      written_count <= written_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held_bytes <= held_next;
  end

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_byte == utf8s_pkg::TERMINATOR |=> held_count == 2'd0 && written_count == 16'd0)
    else $error("terminator did not clear sequence state");

  a_held_below_len: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd0 |-> seq_len > {1'b0, held_count})
    else $error("held bytes reached the expected length");

endmodule

### design/utf8s_result_fifo.sv
// ----------------------------------------------------------------------------
// utf8s_result_fifo
// Result queue: takes a burst of up to four words, hands out one per cycle while popped.
// ----------------------------------------------------------------------------
module utf8s_result_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  utf8s_pkg::utf8s_burst_t   burst,
  input  logic                      pop,
  output logic                      room_ok,
  output logic                      word_valid,
  output utf8s_pkg::utf8s_word_t    word
);

  utf8s_pkg::utf8s_word_t mem [utf8s_pkg::FIFO_DEPTH];

  logic [utf8s_pkg::FIFO_AW-1:0] wr_ptr;
  logic [utf8s_pkg::FIFO_AW-1:0] rd_ptr;
  logic [utf8s_pkg::FIFO_CW-1:0] count;
  logic [utf8s_pkg::FIFO_CW-1:0] push_n;
  logic [utf8s_pkg::FIFO_CW-1:0] pop_n;

  assign push_n     = push ? utf8s_pkg::FIFO_CW'(burst.count) : '0;
  assign pop_n      = pop  ? utf8s_pkg::FIFO_CW'(1) : '0;
  assign room_ok    = count <= utf8s_pkg::FIFO_CW'(utf8s_pkg::FIFO_DEPTH - utf8s_pkg::MAX_BURST);
  assign word_valid = count != '0;
  assign word       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + utf8s_pkg::FIFO_AW'(push_n);
      rd_ptr <= rd_ptr + utf8s_pkg::FIFO_AW'(pop_n);
      count  <= count + push_n - pop_n;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < utf8s_pkg::MAX_BURST; k++) begin
      if (push && utf8s_pkg::BURST_NW'(k) < burst.count) begin
        mem[wr_ptr + utf8s_pkg::FIFO_AW'(k)] <= burst.word[k];
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> room_ok)
    else $error("burst pushed without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= utf8s_pkg::FIFO_CW'(utf8s_pkg::FIFO_DEPTH))
    else $error("queue count above depth");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - utf8s_pkg::FIFO_CW'(1))
    else $error("queue count did not drop on pop");

endmodule

### design/utf8_stream_sanitizer.sv
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer
// Byte-stream UTF-8 sanitizer with replacement and output length cap.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_byte) carries one raw byte per
//   word; a zero byte ends the string. Output channel (out_valid / out_stall /
//   out_byte / last_of_string) carries one sanitized byte per word, and the
//   zero terminator of each string comes out with last_of_string set.
//   One input byte yields zero to four output words.
//   Each byte's words are written into the result queue when the byte is
//   taken and leave from the queue's head. Throughput: one input byte per
//   cycle, as long as the eight-entry result queue has room for a full
//   four-word burst; bursts drain at one word per cycle while out_stall is low.
//   in_stall rises only when the queue is more than half full, so the input
//   keeps flowing while the receiver stalls briefly; a long receiver stall
//   fills the queue and then holds the input.
//   cfg_write / cfg_data set the output capacity (terminator included);
//   write it while the block is idle. Zero acts as one, above 65536 as 65536.
//   Reset empties the queue, drops any partial sequence, zeroes the text
//   count and returns the capacity to 256.
// ----------------------------------------------------------------------------
module utf8_stream_sanitizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_string
);

  // Text bytes allowed per string, capacity minus one, kept ready-made.
  logic [15:0] text_limit;
  logic [15:0] text_limit_next;

  logic                      in_accept;
  logic                      out_accept;
  logic                      room_ok;
  utf8s_pkg::utf8s_burst_t   burst;
  utf8s_pkg::utf8s_word_t    head_word;

  // Clamp the capacity to 1..65536 and take one off for the terminator.
  always_comb begin
    if (cfg_data == 17'd0)             text_limit_next = 16'd0;
    else if (cfg_data > 17'd65536)     text_limit_next = 16'hFFFF;
    else                               text_limit_next = 16'(cfg_data - 17'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_limit <= 16'(utf8s_pkg::CAP_RESET_LIMIT);
    end else if (cfg_write) begin
      text_limit <= text_limit_next;
    end
  end

  // Stall the input only on queue occupancy, never on out_stall directly.
  assign in_stall   = !room_ok;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // Decide the burst for this byte and advance the sequence state.
  utf8s_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .in_byte    (in_byte),
    .text_limit (text_limit),
    .burst      (burst)
  );

  // Hold results until the receiver takes them, one word per cycle.
  utf8s_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (in_accept),
    .burst      (burst),
    .pop        (out_accept),
    .room_ok    (room_ok),
    .word_valid (out_valid),
    .word       (head_word)
  );

  assign out_byte       = head_word.data;
  assign last_of_string = head_word.last;

  a_last_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_string |-> out_byte == utf8s_pkg::TERMINATOR)
    else $error("terminator word carries a nonzero byte");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for utf8_stream_sanitizer: directed strings cover
// control bytes, rejected leads, range rules on the first continuation byte,
// the terminator arriving mid-sequence and the output cap. Random strings then
// run under several capacities. Each accepted byte is run through a local
// sanitizer model, and every output word is compared in order.
// ----------------------------------------------------------------------------
module tb_top;

  // Generous bound: around a hundred and fifty bytes, each up to four words,
  // with random stalls, sender gaps and a long hold-off, fit many times over.
  localparam int CYCLE_LIMIT  = 200000;
  // Each byte's words pass through the result queue register; settle after the owed words are out.
  localparam int DRAIN_CYCLES = 8;
  // Long receiver hold-off, long enough to fill the eight-word queue.
  localparam int HOLD_CYCLES  = 80;
  // Least number of bytes sent over the whole run, directed tests included.
  localparam int TOTAL_ITEMS  = 120;
  localparam int REPORT_MAX   = 10;

  localparam logic [7:0]  CH_TAB = 8'h09;
  localparam logic [7:0]  CH_LF  = 8'h0A;
  localparam logic [7:0]  CH_CR  = 8'h0D;
  localparam logic [7:0]  CH_SP  = 8'h20;
  localparam logic [16:0] CAP_TOP = 17'd65536;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_mode_t;
  typedef logic [7:0] byte_list_t[$];

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [16:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        last_of_string;

  utf8_stream_sanitizer DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .last_of_string (last_of_string)
  );

  // --------------------------------------------------------------------------
  // Sanitizer model state: capacity register, held lead and continuation
  // bytes, and the text count of the current string.
  // --------------------------------------------------------------------------
  logic [16:0]  capacity_reg;
  logic [7:0]   held_seq [3];
  int           held_num;
  int           seq_want;
  logic [15:0]  text_written;

  utf8s_pkg::utf8s_word_t  pending_words[$];   // words still owed by the block, oldest first
  int           errors;
  int           sent_bytes;         // bytes taken by the block so far

  // Sender and receiver pacing.
  int           burst_left;
  bit           no_gaps;
  stall_mode_t  stall_mode;
  int           hold_left;
  int           stall_tick;
  int           cycle_count;

  // Text bytes allowed per string; zero acts as one, anything above the top
  // acts as the top.
  function automatic logic [16:0] text_limit(input logic [16:0] cap);
    if (cap == 17'd0) return 17'd0;
    if (cap > CAP_TOP) return CAP_TOP - 17'd1;
    return cap - 17'd1;
  endfunction

  // Emit one text word if the cap still allows it.
  function automatic void emit_text(input logic [7:0] b);
    utf8s_pkg::utf8s_word_t w;
    if ({1'b0, text_written} < text_limit(capacity_reg)) begin
      w.data = b;
      w.last = 1'b0;
      pending_words.insert(pending_words.size(), w);
      text_written = text_written + 16'd1;
    end
  endfunction

  // A broken sequence: every held byte turns into '?'.
  function automatic void flush_held();
    for (int i = 0; i < held_num; i++) emit_text(utf8s_pkg::QMARK);
    held_num = 0;
    seq_want = 0;
  endfunction

  // Advance the model by one input byte and queue the words it yields.
  function automatic void sanitize_byte(input logic [7:0] b);
    utf8s_pkg::utf8s_word_t term;
    bit          cont_ok;
    int          len;
    if (b == utf8s_pkg::TERMINATOR) begin
      flush_held();
      term.data = utf8s_pkg::TERMINATOR;
      term.last = 1'b1;
      pending_words.insert(pending_words.size(), term);
      text_written = 16'd0;
      return;
    end
    if ({1'b0, text_written} >= text_limit(capacity_reg)) begin
      held_num = 0;
      seq_want = 0;
      return;
    end
    if (held_num > 0) begin
      cont_ok = (b[7:6] == 2'b10);
      // Range rules apply only to the first continuation byte.
      if (cont_ok && held_num == 1) begin
        case (held_seq[0])
          8'hE0: cont_ok = (b >= 8'hA0);   // overlong three-byte form
          8'hED: cont_ok = (b <= 8'h9F);   // surrogate range
          8'hF0: cont_ok = (b >= 8'h90);   // overlong four-byte form
          8'hF4: cont_ok = (b <= 8'h8F);   // above U+10FFFF
          default: ;
        endcase
      end
      if (cont_ok) begin
        if (held_num + 1 >= seq_want) begin
          for (int i = 0; i < held_num; i++) emit_text(held_seq[i]);
          emit_text(b);
          held_num = 0;
          seq_want = 0;
        end else begin
          held_seq[held_num] = b;
          held_num++;
        end
        return;
      end
      // The byte that broke the sequence is looked at afresh below.
      flush_held();
    end
    if (b < 8'h80) begin
      if (b < CH_SP && b != CH_TAB && b != CH_LF && b != CH_CR) emit_text(utf8s_pkg::QMARK);
      else emit_text(b);
      return;
    end
    len = 0;
    if (b[7:5] == 3'b110)       len = (b >= 8'hC2) ? 2 : 0;
    else if (b[7:4] == 4'b1110) len = 3;
    else if (b[7:3] == 5'b11110) len = (b <= 8'hF4) ? 4 : 0;
    if (len == 0) begin
      emit_text(utf8s_pkg::QMARK);
    end else begin
      held_seq[0] = b;
      held_num = 1;
      seq_want = len;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock, cycle guard
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL utf8_stream_sanitizer");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern picked per phase. A requested hold-off wins
  // over the pattern and is counted down here at each falling edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        STALL_NONE:    out_stall <= 1'b0;
        STALL_RANDOM:  out_stall <= ($urandom_range(0, 99) < 30);
        STALL_PATTERN: out_stall <= ((stall_tick % 7) < 3);
        default:       out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
    stall_tick++;
  end

  // --------------------------------------------------------------------------
  // Monitor: everything that happens at a rising edge is handled in one place,
  // so the order of prediction and checking never depends on the simulator.
  // Config first, then the input word, then the output word.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    utf8s_pkg::utf8s_word_t want;
    if (!rst) begin
      if (cfg_write) capacity_reg = cfg_data;
      if (in_valid && !in_stall) begin
        sanitize_byte(in_byte);
      end
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("unexpected word: data=%02h last=%0b", out_byte, last_of_string);
        end else begin
          want = pending_words.pop_front();
          if (out_byte !== want.data || last_of_string !== want.last) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("word mismatch: expected data=%02h last=%0b, got data=%02h last=%0b",
                       want.data, want.last, out_byte, last_of_string);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared driving tasks
  // --------------------------------------------------------------------------

  // Offer one byte and hold it until taken. Bursts of random length are
  // separated by random gaps unless gaps are switched off for the phase.
  // Returns at the rising edge that took the byte; valid stays high so the
  // next byte can follow back to back.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_byte  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_bytes(input byte_list_t bytes);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // Drop valid, wait for every owed word, then let the pipeline settle so a
  // byte that yields nothing is surely through as well.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Call only when drained.
  task automatic write_capacity(input logic [16:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // First continuation byte that keeps the sequence legal for this lead.
  function automatic logic [7:0] legal_second(input logic [7:0] lead);
    case (lead)
      8'hE0:   return 8'($urandom_range(8'hA0, 8'hBF));
      8'hED:   return 8'($urandom_range(8'h80, 8'h9F));
      8'hF0:   return 8'($urandom_range(8'h90, 8'hBF));
      8'hF4:   return 8'($urandom_range(8'h80, 8'h8F));
      default: return cont_byte();
    endcase
  endfunction

  // One string of random tokens: mostly well-formed characters, some noise
  // bytes and broken sequences, then the terminator.
  task automatic send_random_string();
    int          tokens;
    int          pick;
    logic [7:0]  lead;
    tokens = $urandom_range(0, 10);
    repeat (tokens) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_byte(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 40) begin
        send_byte(8'($urandom_range(8'hC2, 8'hDF)));
        send_byte(cont_byte());
      end else if (pick < 55) begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        send_byte(lead);
        send_byte(legal_second(lead));
        send_byte(cont_byte());
      end else if (pick < 70) begin
        lead = 8'($urandom_range(8'hF0, 8'hF4));
        send_byte(lead);
        send_byte(legal_second(lead));
        send_byte(cont_byte());
        send_byte(cont_byte());
      end else if (pick < 85) begin
        // Any non-zero byte at all.
        send_byte(8'($urandom_range(1, 255)));
      end else begin
        // Lead, up to two continuation bytes, then a byte that is not a continuation.
        send_byte(8'($urandom_range(8'hC2, 8'hF4)));
        repeat ($urandom_range(0, 2)) send_byte(cont_byte());
        if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(1, 8'h7F)));
        else send_byte(8'($urandom_range(8'hC0, 8'hFF)));
      end
    end
    send_byte(utf8s_pkg::TERMINATOR);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Tab, LF, CR and printables pass; other C0 controls turn into '?'.
  task automatic test_ascii_and_controls();
    stall_mode = STALL_NONE;
    no_gaps = 1'b1;
    send_bytes('{CH_TAB, CH_LF, CH_CR, 8'h01, 8'h1F, 8'h7F, CH_SP,
                 utf8s_pkg::TERMINATOR});
    wait_drained();
  endtask

  // Leads that can never start a character, and a stray continuation byte.
  task automatic test_rejected_leads();
    stall_mode = STALL_RANDOM;
    no_gaps = 1'b0;
    send_bytes('{8'hC0, 8'hC1, 8'hF5, 8'hFF, 8'h80, utf8s_pkg::TERMINATOR});
    wait_drained();
  endtask

  // Overlongs, surrogates, above U+10FFFF, the top legal four-byte form, and
  // a terminator arriving while three bytes are held.
  task automatic test_range_rules();
    stall_mode = STALL_PATTERN;
    send_bytes('{8'hE0, 8'h9F, 8'hED, 8'hA0, 8'hF0, 8'h8F, 8'hF4, 8'h90,
                 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hC2, 8'h41,
                 8'hF0, 8'h90, 8'h80, utf8s_pkg::TERMINATOR});
    wait_drained();
  endtask

  // Cap at both ends of the register, sequences cut at the cap, and a cap
  // lowered in the middle of a string.
  task automatic test_capacity();
    stall_mode = STALL_RANDOM;
    write_capacity(17'd1);
    send_bytes('{8'h61, 8'h62, utf8s_pkg::TERMINATOR});
    wait_drained();
    write_capacity(17'd0);
    send_bytes('{8'h41, 8'hE2, utf8s_pkg::TERMINATOR});
    wait_drained();
    write_capacity(17'd3);
    send_bytes('{8'hE2, 8'h82, 8'hAC, 8'h41, utf8s_pkg::TERMINATOR});
    wait_drained();
    write_capacity(17'd4);
    send_bytes('{8'hF0, 8'h90, 8'h80, utf8s_pkg::TERMINATOR});
    wait_drained();
    write_capacity(17'h1FFFF);
    send_bytes('{8'h48, 8'hC3, 8'hA9, utf8s_pkg::TERMINATOR});
    wait_drained();
    write_capacity(17'd100000);
    send_bytes('{8'hF3, 8'hBF, 8'hBF, 8'hBF, utf8s_pkg::TERMINATOR});
    wait_drained();
    write_capacity(CAP_TOP);
    send_bytes('{8'h41, utf8s_pkg::TERMINATOR});
    wait_drained();
    // Three bytes of text, then drop the cap to one byte below that.
    write_capacity(17'd256);
    send_bytes('{8'h61, 8'h62, 8'h63});
    wait_drained();
    write_capacity(17'd2);
    send_bytes('{8'h64, 8'hC3, 8'hA9, utf8s_pkg::TERMINATOR});
    wait_drained();
    write_capacity(17'd256);
  endtask

  // Receiver holds off for a long stretch while bytes keep coming, so the
  // result queue fills and the input stalls; then the sender pauses until
  // every word is out.
  task automatic test_backpressure();
    stall_mode = STALL_NONE;
    no_gaps = 1'b1;
    hold_left = HOLD_CYCLES;
    repeat (12) send_byte(8'($urandom_range(8'h20, 8'h7E)));
    repeat (4) begin
      send_byte(8'hF0);
      send_byte(8'hA0);
      send_byte(cont_byte());
      send_byte(cont_byte());
    end
    send_byte(utf8s_pkg::TERMINATOR);
    wait_drained();
  endtask

  // Random strings over several capacities, with pacing changed per phase,
  // until the run has sent its share of bytes.
  task automatic test_random_strings();
    logic [16:0] caps[5];
    int          phase;
    caps  = '{17'd5, 17'd256, 17'd17, CAP_TOP, 17'd2};
    phase = 0;
    while (sent_bytes < TOTAL_ITEMS) begin
      wait_drained();
      write_capacity(caps[phase % 5]);
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 4)) send_random_string();
      phase++;
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 17'd0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    out_stall = 1'b0;
    capacity_reg = 17'd256;
    held_seq = '{8'h00, 8'h00, 8'h00};
    held_num = 0;
    seq_want = 0;
    text_written = 16'd0;
    errors = 0;
    sent_bytes = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    stall_mode = STALL_NONE;
    hold_left = 0;
    stall_tick = 0;
    cycle_count = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_ascii_and_controls();
    test_rejected_leads();
    test_range_rules();
    test_capacity();
    test_backpressure();
    test_random_strings();

    wait_drained();
    if (errors == 0 && pending_words.size() == 0) begin
      $display("PASS utf8_stream_sanitizer");
    end else begin
      $display("FAIL utf8_stream_sanitizer");
    end
    $finish;
  end

endmodule

### filelist.f
design/utf8s_pkg.sv
design/utf8s_decode.sv
design/utf8s_result_fifo.sv
design/utf8_stream_sanitizer.sv
verif/tb_top.sv
